// ----- rtl/core/tlde_pkg.sv -----
`timescale 1ns / 1ps

package tlde_pkg;

   localparam logic [2:0]  PH_FIRST         = 3'd0;
   localparam logic [2:0]  PH_WAIT          = 3'd6;
   localparam logic [1:0]  BLINK_WRAP       = 2'd2;
   localparam logic [6:0]  VALUE_MIN        = 7'd1;
   localparam logic [6:0]  VALUE_MAX        = 7'd99;
   localparam logic [7:0]  VALUE_MODULUS    = 8'd100;
   localparam logic [13:0] TICKS_PER_SECOND = 14'd100;

   typedef struct packed {
      logic blink_expired;
      logic apply_pressed;
      logic inc_pressed;
      logic dec_pressed;
      logic mode_pressed;
      logic start_edit;
   } req_type;

   typedef struct packed {
      logic [2:0]  edit_phase;
      logic [5:0]  led_pattern;
      logic [6:0]  shown_value;
      logic        show_value;
      logic        duration_written;
      logic [2:0]  duration_slot;
      logic [13:0] duration_value;
      logic        return_to_auto;
      logic        restart_blink_timer;
   } rsp_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [1:0] blink;
      logic [6:0] value;
      logic [5:0] led;
   } state_type;

endpackage

// ----- rtl/core/traffic_light_duration_editor.sv -----
`timescale 1ns / 1ps

// Channel   Direction   Handshake              Word
// req       in          req_valid / req_stall  req_word (req_type)
// rsp       out         rsp_valid / rsp_stall  rsp_word (rsp_type)
//
// An accepted word is held in the input register, and its result is then
// loaded into the output register once that register is empty or unstalled.
// A new word can be accepted every cycle while the result side keeps up.
// Reset puts the editor in the waiting state with the value at one and
// all lights off. A stall on the result side holds both registers and
// raises req_stall once the input register is occupied.

module traffic_light_duration_editor
   import tlde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic      in_vld_ff;
   logic      in_vld_in;
   req_type   in_word_ff;
   logic      out_vld_ff;
   logic      out_vld_in;
   rsp_type   out_word_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;
   logic      advance;
   logic      req_take;

   tlde_step u_step (
      .cur_state (state_ff),
      .req_word  (in_word_ff),
      .nxt_state (state_in),
      .rsp_word  (step_rsp)
   );

   assign advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !advance;
   assign req_take   = req_valid && !req_stall;
   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '{phase: PH_WAIT, blink: 2'd0, value: VALUE_MIN, led: 6'd0};
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= step_rsp;
      end
   end

endmodule

// ----- rtl/core/tlde_step.sv -----
`timescale 1ns / 1ps

module tlde_step
   import tlde_pkg::*;
(
   input  state_type cur_state,
   input  req_type   req_word,
   output state_type nxt_state,
   output rsp_type   rsp_word
);

   logic [2:0] ph_next;
   logic [2:0] partner;
   logic [1:0] blink_inc;
   logic [7:0] inc_sum;
   logic [6:0] shown;
   logic       show;

   assign ph_next   = cur_state.phase + 3'd1;
   assign blink_inc = cur_state.blink + 2'd1;

   always_comb begin
      case (cur_state.phase)
         3'd0:    partner = 3'd3;
         3'd1:    partner = 3'd4;
         3'd2:    partner = 3'd5;
         3'd3:    partner = 3'd0;
         3'd4:    partner = 3'd1;
         3'd5:    partner = 3'd2;
         default: partner = 3'd0;
      endcase
   end

   always_comb begin
      nxt_state = cur_state;
      rsp_word  = '0;
      inc_sum   = '0;
      shown     = cur_state.value;
      show      = 1'b0;
      if (cur_state.phase >= PH_WAIT) begin
         if (req_word.start_edit) begin
            nxt_state.phase = PH_FIRST;
         end
      end else begin
         if (req_word.blink_expired) begin
            rsp_word.restart_blink_timer = 1'b1;
            if (blink_inc > BLINK_WRAP) begin
               nxt_state.blink = 2'd0;
               nxt_state.led   = (6'd1 << cur_state.phase) | (6'd1 << partner);
            end else begin
               nxt_state.blink = blink_inc;
               nxt_state.led   = 6'd1 << cur_state.phase;
            end
         end
         if (req_word.apply_pressed) begin
            nxt_state.led             = '0;
            rsp_word.duration_written = 1'b1;
            rsp_word.duration_slot    = cur_state.phase;
            rsp_word.duration_value   = {7'd0, cur_state.value} * TICKS_PER_SECOND;
            nxt_state.value           = VALUE_MIN;
            nxt_state.phase           = ph_next;
            if (ph_next >= PH_WAIT) begin
               rsp_word.return_to_auto = 1'b1;
            end
         end
         if (req_word.inc_pressed) begin
            inc_sum = {1'b0, nxt_state.value} + 8'd1;
            if (inc_sum >= VALUE_MODULUS) begin
               inc_sum = inc_sum - VALUE_MODULUS;
            end
            if (inc_sum == 8'd0) begin
               inc_sum = 8'd1;
            end
            nxt_state.value = inc_sum[6:0];
            show            = 1'b1;
            shown           = inc_sum[6:0];
         end
         if (req_word.dec_pressed) begin
            if (nxt_state.value <= VALUE_MIN) begin
               nxt_state.value = VALUE_MAX;
            end else begin
               nxt_state.value = nxt_state.value - 7'd1;
            end
            show  = 1'b1;
            shown = nxt_state.value;
         end
         if (req_word.mode_pressed) begin
            nxt_state.led   = '0;
            nxt_state.value = VALUE_MIN;
            nxt_state.phase = ph_next;
            if (ph_next >= PH_WAIT) begin
               rsp_word.return_to_auto = 1'b1;
            end
         end
      end
      rsp_word.edit_phase  = nxt_state.phase;
      rsp_word.led_pattern = nxt_state.led;
      rsp_word.show_value  = show;
      rsp_word.shown_value = show ? shown : nxt_state.value;
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import tlde_pkg::*;

   localparam int ITEM_COUNT   = 2000;
   localparam int HANG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;

   class editor_scoreboard;
      logic [2:0] phase;
      logic [1:0] blink;
      logic [6:0] value;
      logic [5:0] led;
      rsp_type    expected_words[$];
      int         errors;

      function new();
         phase  = PH_WAIT;
         blink  = '0;
         value  = VALUE_MIN;
         led    = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_word(req_type w);
         rsp_type    r;
         logic [2:0] ph;
         logic [2:0] nxt;
         int         partner;
         r  = '0;
         ph = phase;
         if (ph >= PH_WAIT) begin
            if (w.start_edit) phase = PH_FIRST;
         end else begin
            nxt     = ph + 3'd1;
            partner = (int'(ph) + 3) % 6;
            if (w.blink_expired) begin
               r.restart_blink_timer = 1'b1;
               led   = '0;
               blink = blink + 2'd1;
               if (blink > BLINK_WRAP) begin
                  blink        = '0;
                  led[partner] = 1'b1;
               end
               led[ph] = 1'b1;
            end
            if (w.apply_pressed) begin
               led                = '0;
               r.duration_written = 1'b1;
               r.duration_slot    = ph;
               r.duration_value   = {7'd0, value} * TICKS_PER_SECOND;
               value              = VALUE_MIN;
               phase              = nxt;
               if (nxt >= PH_WAIT) r.return_to_auto = 1'b1;
            end
            if (w.inc_pressed) begin
               value         = (value >= VALUE_MAX) ? VALUE_MIN : value + 7'd1;
               r.show_value  = 1'b1;
               r.shown_value = value;
            end
            if (w.dec_pressed) begin
               value         = (value <= VALUE_MIN) ? VALUE_MAX : value - 7'd1;
               r.show_value  = 1'b1;
               r.shown_value = value;
            end
            if (w.mode_pressed) begin
               led   = '0;
               value = VALUE_MIN;
               phase = nxt;
               if (nxt >= PH_WAIT) r.return_to_auto = 1'b1;
            end
         end
         if (!r.show_value) r.shown_value = value;
         r.edit_phase  = phase;
         r.led_pattern = led;
         expected_words.push_back(r);
      endfunction

      function void compare_field(string name, logic [13:0] want, logic [13:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("edit_phase", 14'(want.edit_phase), 14'(got.edit_phase));
         compare_field("led_pattern", 14'(want.led_pattern), 14'(got.led_pattern));
         compare_field("shown_value", 14'(want.shown_value), 14'(got.shown_value));
         compare_field("show_value", 14'(want.show_value), 14'(got.show_value));
         compare_field("duration_written", 14'(want.duration_written),
                       14'(got.duration_written));
         compare_field("duration_slot", 14'(want.duration_slot), 14'(got.duration_slot));
         compare_field("duration_value", want.duration_value, got.duration_value);
         compare_field("return_to_auto", 14'(want.return_to_auto),
                       14'(got.return_to_auto));
         compare_field("restart_blink_timer", 14'(want.restart_blink_timer),
                       14'(got.restart_blink_timer));
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   bit      calm = 1'b0;
   int      sent = 0;
   int      quiet_cycles = 0;

   editor_scoreboard editor = new();

   traffic_light_duration_editor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) editor.note_word(req_word);
         if (rsp_valid && !rsp_stall) editor.check_word(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("traffic_light_duration_editor: mismatch");
            $finish;
         end
      end
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   function automatic req_type make_word(bit expired, bit apply, bit inc, bit dec,
                                         bit mode, bit start);
      req_type w;
      w.blink_expired = expired;
      w.apply_pressed = apply;
      w.inc_pressed   = inc;
      w.dec_pressed   = dec;
      w.mode_pressed  = mode;
      w.start_edit    = start;
      return w;
   endfunction

   task automatic send_word(input req_type w);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (editor.pending() != 0) @(posedge clock);
   endtask

   task automatic edit_session();
      int      n;
      req_type w;
      send_word(make_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b1));
      sent++;
      for (int ph = 0; ph < 6; ph++) begin
         n = $urandom_range(0, 6);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
               w = req_type'(6'($urandom_range(0, 63)));
            end else begin
               w = make_word(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0,
                             $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0);
            end
            send_word(w);
            sent++;
         end
         w = make_word(1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 2) == 0,
                       $urandom_range(0, 3) == 0, 1'b0, $urandom_range(0, 7) == 0);
         case ($urandom_range(0, 2))
            0: begin
               w.apply_pressed = 1'b1;
            end
            1: begin
               w.mode_pressed = 1'b1;
            end
            default: begin
               w.apply_pressed = 1'b1;
               w.mode_pressed  = 1'b1;
            end
         endcase
         send_word(w);
         sent++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Everything is ignored while waiting, except the start of an edit.
      send_word(make_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
      send_word(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_word(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_word(make_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
      send_word(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_word(make_word(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_word(make_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
      send_word(make_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_word(make_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_word(make_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      repeat (5) send_word(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      pause_until_drained();

      while (sent < ITEM_COUNT) begin
         if ($urandom_range(0, 3) == 0) send_word(req_type'(6'($urandom_range(0, 63))));
         edit_session();
         if (!calm && $urandom_range(0, 7) == 0) pause_until_drained();
         if (sent > ITEM_COUNT * 17 / 20) calm = 1'b1;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (editor.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (editor.errors == 0 && editor.pending() == 0) begin
         $display("traffic_light_duration_editor: match");
      end else begin
         $display("traffic_light_duration_editor: mismatch");
      end
      $finish;
   end

endmodule

// ----- traffic_light_duration_editor.f -----
rtl/core/tlde_pkg.sv
rtl/core/tlde_step.sv
rtl/core/traffic_light_duration_editor.sv
sim/tb_top.sv
